/* hdl/tlbpt_pkg.sv */
`default_nettype none

package tlbpt_pkg;

    // Fixed geometry of the translator.
    localparam int ADDR_W       = 16;
    localparam int TLB_ENTRIES  = 16;
    localparam int PAGE_COUNT   = 256;
    localparam int OFFSET_WIDTH = 8;

    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
    localparam int NFF_W     = PAGE_W + 1;
    localparam int PHYS_W    = PAGE_W + OFFSET_WIDTH;

    // Result flags in tuser, lowest bit first.
    localparam int USER_W       = 3;
    localparam int USER_HIT_BIT = 0;
    localparam int USER_PF_BIT  = 1;
    localparam int USER_OOF_BIT = 2;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* hdl/tlbpt_ctrl.sv */
`default_nettype none

module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            ST_LOOKUP: begin
                // State only changes when the result can be loaded.
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/tlbpt_datapath.sv */
`default_nettype none

module tlbpt_datapath
    import tlbpt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [ADDR_W-1:0] i_s_tdata,
    input  wire t_ctrl_cmd         i_cmd,
    output t_dp_status             o_status,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [ADDR_W-1:0]      o_m_tdata,
    output logic [USER_W-1:0]      o_m_tuser
);

    // Captured address and registered page table read.
    logic [ADDR_W-1:0] r_addr;
    logic [PAGE_W-1:0] r_pt_rdata;
    logic [PAGE_W-1:0] r_page_frame [PAGE_COUNT];

    // TLB storage.
    logic [PAGE_W-1:0]    r_tlb_tag   [TLB_ENTRIES];
    logic [PAGE_W-1:0]    r_tlb_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [TLB_IDX_W-1:0] r_tlb_ptr;

    logic [PAGE_COUNT-1:0] r_page_mapped;
    logic [NFF_W-1:0]      r_next_free;

    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_data;
    logic [USER_W-1:0]   r_out_user;

    logic [ADDR_W-1:0]       w_in_shift;
    logic [PAGE_W-1:0]       w_in_page;
    logic [ADDR_W-1:0]       w_shift;
    logic [PAGE_W-1:0]       w_page;
    logic [OFFSET_WIDTH-1:0] w_offset;
    logic                    w_hit;
    logic [PAGE_W-1:0]       w_hit_frame;
    logic                    w_mapped;
    logic                    w_oof;
    logic                    w_fault;
    logic [PAGE_W-1:0]       w_frame;
    logic [PHYS_W-1:0]       w_phys;
    logic [TLB_IDX_W-1:0]    w_slot;

    assign w_in_shift = i_s_tdata >> OFFSET_WIDTH;
    assign w_in_page  = w_in_shift[PAGE_W-1:0];
    assign w_shift    = r_addr >> OFFSET_WIDTH;
    assign w_page     = w_shift[PAGE_W-1:0];
    assign w_offset   = r_addr[OFFSET_WIDTH-1:0];

    // Fully associative compare; the lowest matching entry wins.
    always_comb begin
        w_hit       = 1'b0;
        w_hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_tag[i] == w_page)) begin
                w_hit       = 1'b1;
                w_hit_frame = r_tlb_frame[i];
            end
        end
    end

    assign w_mapped = r_page_mapped[w_page];
    assign w_oof    = !w_hit && !w_mapped && (r_next_free == NFF_W'(PAGE_COUNT));
    assign w_fault  = !w_hit && !w_mapped && !w_oof;

    always_comb begin
        if (w_hit) begin
            w_frame = w_hit_frame;
        end else if (w_mapped) begin
            w_frame = r_pt_rdata;
        end else begin
            w_frame = r_next_free[PAGE_W-1:0];
        end
    end

    assign w_phys = {w_frame, w_offset};
    assign w_slot = (r_tlb_ptr == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0
                                                                : r_tlb_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr     <= i_s_tdata;
            r_pt_rdata <= r_page_frame[w_in_page];
        end
        if (i_cmd.commit && w_fault) begin
            r_page_frame[w_page] <= r_next_free[PAGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !w_hit && !w_oof) begin
            r_tlb_tag[w_slot]   <= w_page;
            r_tlb_frame[w_slot] <= w_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid   <= '0;
            r_tlb_ptr     <= '0;
            r_page_mapped <= '0;
            r_next_free   <= '0;
        end else if (i_cmd.commit) begin
            if (!w_hit && !w_oof) begin
                r_tlb_valid[w_slot] <= 1'b1;
                r_tlb_ptr           <= w_slot;
            end
            if (w_fault) begin
                r_page_mapped[w_page] <= 1'b1;
                r_next_free           <= r_next_free + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data               <= w_oof ? '0 : ADDR_W'(w_phys);
            r_out_user[USER_HIT_BIT] <= w_hit;
            r_out_user[USER_PF_BIT]  <= w_fault;
            r_out_user[USER_OOF_BIT] <= w_oof;
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;
    assign o_m_tuser         = r_out_user;

endmodule

`default_nettype wire

/* hdl/tlb_page_table_translator.sv */
// Address translator with a 16-entry TLB and a 256-entry page table.
//
// Input stream: one 16-bit virtual address per beat (page in the upper
// bits, offset in the lower 8). Output stream: one beat per input beat
// carrying the physical address and the hit, page fault and out-of-frames
// flags. A page fault hands out the next free frame; outside logic uses
// the fault flag to fill that frame.
//
// Timing: an address is taken in the idle state and resolved in the
// lookup state; no new address is taken before the last one resolves.
// The pace is set by the page table memory, whose registered read is
// started as the address is taken and which may be written while the
// lookup resolves. The lookup waits for a free output register.
//
// Stalls: the result sits in an output register until taken; the input
// is ready again meanwhile and the next address waits in the lookup stage
// until the output register frees up.
//
// Reset clears the TLB valid bits, the mapped bits of the page table, the
// free frame counter and the output valid; no clearing pass is needed.
`default_nettype none

module tlb_page_table_translator
    import tlbpt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [ADDR_W-1:0] i_s_tdata,  // [15:0] virt_addr
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [ADDR_W-1:0]      o_m_tdata,  // [15:0] phys_addr
    output logic [USER_W-1:0]      o_m_tuser   // [0] tlb_hit, [1] page_fault,
                                               // [2] out_of_frames
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    tlbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tlbpt_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* hdl/tlbpt_checker.sv */
`default_nettype none

module tlbpt_checker
    import tlbpt_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [ADDR_W-1:0] o_m_tdata,
    input wire logic [USER_W-1:0] o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("output beat dropped or changed while stalled");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot0(o_m_tuser))
        else $error("more than one result flag set");

    a_oof_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USER_OOF_BIT] |-> o_m_tdata == '0)
        else $error("out of frames with nonzero address");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while a lookup is pending");

    // An input beat taken while the output is free goes to the lookup state, then into the output register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (!o_m_tvalid || i_m_tready) |-> ##2 o_m_tvalid)
        else $error("no result two cycles after an unstalled input beat");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
